// File: rtl/crcfr_pkg.sv
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared constants, types and the byte-wide CRC-16/MODBUS step for the
// framed command receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam int FRAME_BYTES = 38;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  localparam logic [POS_W-1:0] POS_HUNT   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SYNC2  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CMD    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_PARAM  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);

  localparam logic [7:0]  SYNC_FIRST  = 8'h55;
  localparam logic [7:0]  SYNC_SECOND = 8'hAA;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  localparam logic [7:0] CMD_PUMP_STOP  = 8'h01;
  localparam logic [7:0] CMD_PUMP_START = 8'h02;
  localparam logic [7:0] CMD_PUMP_POWER = 8'h03;
  localparam logic [7:0] CMD_LIGHT_SET  = 8'h10;
  localparam logic [7:0] CMD_LIGHT_OFF  = 8'h11;

  localparam logic [7:0] LIGHT_MODE_OFF = 8'hFF;
  localparam logic [7:0] PUMP_DEFAULT   = 8'd60;
  localparam logic [7:0] PUMP_MAX       = 8'd100;

  // end-of-frame event from the framer to the command stage
  typedef struct packed {
    logic       done;
    logic       crc_ok;
    logic [7:0] cmd;
    logic [7:0] param;
  } frame_evt_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/crcfr_if.sv
// ----------------------------------------------------------------------------
// crcfr_if
// Valid/ready channels: received bytes in, per-frame results out.
// ----------------------------------------------------------------------------
interface crcfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcfr_out_if;
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic        command_known;
  logic        pump_on;
  logic        pump_manual;
  logic [6:0]  pump_power;
  logic        light_on;
  logic [7:0]  light_mode;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;

  modport source (output valid, output crc_ok, output command_known, output pump_on,
                  output pump_manual, output pump_power, output light_on,
                  output light_mode, output good_frames, output bad_frames,
                  input ready);
  modport sink   (input valid, input crc_ok, input command_known, input pump_on,
                  input pump_manual, input pump_power, input light_on,
                  input light_mode, input good_frames, input bad_frames,
                  output ready);
endinterface

// File: rtl/crc_framed_command_receiver_top.sv
// ----------------------------------------------------------------------------
// crc_framed_command_receiver_top
// A frame's result is registered and valid in the cycle after its last byte transfer.
// Throughput: one byte per cycle; the last byte of a frame waits only while
// the previous frame's result is still untaken at the output register.
// Reset (async, active low): hunts for sync, crc reseeded, settings and
// frame counters cleared, no result pending.
// ----------------------------------------------------------------------------
module crc_framed_command_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  crcfr_in_if.sink    in_i,
  crcfr_out_if.source out_o
);

  logic                  accept;
  logic                  at_last;
  crcfr_pkg::frame_evt_t evt;

  // only a frame-ending byte needs the result slot
  assign in_i.ready = ~(at_last & out_o.valid & ~out_o.ready);
  assign accept     = in_i.valid & in_i.ready;

  crcfr_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (in_i.rx_byte),
    .at_last_o (at_last),
    .evt_o     (evt)
  );

  crcfr_apply u_apply (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt),
    .out_o  (out_o)
  );

endmodule

// File: rtl/crcfr_framer.sv
// ----------------------------------------------------------------------------
// crcfr_framer
// Sync hunt, byte position tracking and running CRC from the first sync byte up to the CRC field.
// Flags the end of each frame together with the CRC verdict.
// ----------------------------------------------------------------------------
module crcfr_framer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  at_last_o,
  output crcfr_pkg::frame_evt_t evt_o
);

  logic [crcfr_pkg::POS_W-1:0] pos_q, pos_d;
  logic [15:0]                 crc_q, crc_d;
  logic [7:0]                  cmd_q, cmd_d;
  logic [7:0]                  param_q, param_d;
  logic [7:0]                  crc_lo_q, crc_lo_d;
  logic [15:0]                 crc_fed;

  assign crc_fed   = crcfr_pkg::crc_feed(crc_q, rx_byte_i);
  assign at_last_o = (pos_q > crcfr_pkg::POS_CRC_LO);

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    cmd_d       = cmd_q;
    param_d     = param_q;
    crc_lo_d    = crc_lo_q;
    evt_o.done   = 1'b0;
    evt_o.crc_ok = ({rx_byte_i, crc_lo_q} == crc_q);
    evt_o.cmd    = cmd_q;
    evt_o.param  = param_q;
    if (accept_i) begin
      if (pos_q == crcfr_pkg::POS_HUNT) begin
        if (rx_byte_i == crcfr_pkg::SYNC_FIRST) begin
          crc_d = crcfr_pkg::crc_feed(crcfr_pkg::CRC_INIT, rx_byte_i);
          pos_d = crcfr_pkg::POS_SYNC2;
        end
      end else if (pos_q == crcfr_pkg::POS_SYNC2) begin
        if (rx_byte_i == crcfr_pkg::SYNC_SECOND) begin
          crc_d = crc_fed;
          pos_d = crcfr_pkg::POS_CMD;
        end else if (rx_byte_i == crcfr_pkg::SYNC_FIRST) begin
          // repeated first sync byte restarts the hunt on this byte
          crc_d = crcfr_pkg::crc_feed(crcfr_pkg::CRC_INIT, rx_byte_i);
          pos_d = crcfr_pkg::POS_SYNC2;
        end else begin
          crc_d = crcfr_pkg::CRC_INIT;
          pos_d = crcfr_pkg::POS_HUNT;
        end
      end else if (pos_q < crcfr_pkg::POS_CRC_LO) begin
        if (pos_q == crcfr_pkg::POS_CMD) begin
          cmd_d = rx_byte_i;
        end
        if (pos_q == crcfr_pkg::POS_PARAM) begin
          param_d = rx_byte_i;
        end
        crc_d = crc_fed;
        pos_d = pos_q + crcfr_pkg::POS_W'(1);
      end else if (pos_q == crcfr_pkg::POS_CRC_LO) begin
        crc_lo_d = rx_byte_i;
        pos_d    = pos_q + crcfr_pkg::POS_W'(1);
      end else begin
        evt_o.done = 1'b1;
        pos_d      = crcfr_pkg::POS_HUNT;
        crc_d      = crcfr_pkg::CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= crcfr_pkg::POS_HUNT;
      crc_q    <= crcfr_pkg::CRC_INIT;
      cmd_q    <= 8'h00;
      param_q  <= 8'h00;
      crc_lo_q <= 8'h00;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      cmd_q    <= cmd_d;
      param_q  <= param_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= crcfr_pkg::POS_LAST)
    else $error("byte position beyond frame end");

  a_hunt_crc_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == crcfr_pkg::POS_HUNT) |-> (crc_q == crcfr_pkg::CRC_INIT))
    else $error("crc not reseeded while hunting");

endmodule

// File: rtl/crcfr_apply.sv
// ----------------------------------------------------------------------------
// crcfr_apply
// Applies good-CRC commands to the pump and light settings, counts good and
// bad frames, and holds the per-frame result register.
// ----------------------------------------------------------------------------
module crcfr_apply (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crcfr_pkg::frame_evt_t evt_i,
  crcfr_out_if.source           out_o
);

  logic        valid_q, valid_d;
  logic        ok_q, ok_d;
  logic        known_q, known_d;
  logic        pump_en_q, pump_en_d;
  logic        pump_man_q, pump_man_d;
  logic [6:0]  pump_pwr_q, pump_pwr_d;
  logic        light_en_q, light_en_d;
  logic [7:0]  light_mode_q, light_mode_d;
  logic [31:0] good_q, good_d;
  logic [31:0] bad_q, bad_d;
  logic [7:0]  start_pwr;
  logic [6:0]  clamp_param;
  logic [6:0]  clamp_start;

  assign start_pwr   = (evt_i.param == 8'h00) ? crcfr_pkg::PUMP_DEFAULT : evt_i.param;
  assign clamp_param = (evt_i.param > crcfr_pkg::PUMP_MAX) ? crcfr_pkg::PUMP_MAX[6:0]
                                                           : evt_i.param[6:0];
  assign clamp_start = (start_pwr > crcfr_pkg::PUMP_MAX) ? crcfr_pkg::PUMP_MAX[6:0]
                                                         : start_pwr[6:0];

  always_comb begin
    valid_d      = valid_q & ~out_o.ready;
    ok_d         = ok_q;
    known_d      = known_q;
    pump_en_d    = pump_en_q;
    pump_man_d   = pump_man_q;
    pump_pwr_d   = pump_pwr_q;
    light_en_d   = light_en_q;
    light_mode_d = light_mode_q;
    good_d       = good_q;
    bad_d        = bad_q;
    if (evt_i.done) begin
      valid_d = 1'b1;
      ok_d    = evt_i.crc_ok;
      known_d = 1'b0;
      if (evt_i.crc_ok) begin
        good_d = good_q + 32'd1;
        unique case (evt_i.cmd)
          crcfr_pkg::CMD_PUMP_STOP: begin
            known_d    = 1'b1;
            pump_en_d  = 1'b1;
            pump_man_d = 1'b1;
            pump_pwr_d = 7'd0;
          end
          crcfr_pkg::CMD_PUMP_START: begin
            known_d    = 1'b1;
            pump_en_d  = 1'b1;
            pump_man_d = 1'b1;
            pump_pwr_d = clamp_start;
          end
          crcfr_pkg::CMD_PUMP_POWER: begin
            known_d    = 1'b1;
            pump_en_d  = 1'b1;
            pump_man_d = 1'b1;
            pump_pwr_d = clamp_param;
          end
          crcfr_pkg::CMD_LIGHT_SET: begin
            known_d      = 1'b1;
            light_en_d   = 1'b1;
            light_mode_d = evt_i.param;
          end
          crcfr_pkg::CMD_LIGHT_OFF: begin
            known_d      = 1'b1;
            light_mode_d = crcfr_pkg::LIGHT_MODE_OFF;
          end
          default: begin
            known_d = 1'b0;
          end
        endcase
      end else begin
        bad_d = bad_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      ok_q         <= 1'b0;
      known_q      <= 1'b0;
      pump_en_q    <= 1'b0;
      pump_man_q   <= 1'b0;
      pump_pwr_q   <= 7'd0;
      light_en_q   <= 1'b0;
      light_mode_q <= 8'h00;
      good_q       <= 32'd0;
      bad_q        <= 32'd0;
    end else begin
      valid_q      <= valid_d;
      ok_q         <= ok_d;
      known_q      <= known_d;
      pump_en_q    <= pump_en_d;
      pump_man_q   <= pump_man_d;
      pump_pwr_q   <= pump_pwr_d;
      light_en_q   <= light_en_d;
      light_mode_q <= light_mode_d;
      good_q       <= good_d;
      bad_q        <= bad_d;
    end
  end

  // settings only change on a frame end, so they can drive the result directly
  assign out_o.valid         = valid_q;
  assign out_o.crc_ok        = ok_q;
  assign out_o.command_known = known_q;
  assign out_o.pump_on       = pump_en_q;
  assign out_o.pump_manual   = pump_man_q;
  assign out_o.pump_power    = pump_pwr_q;
  assign out_o.light_on      = light_en_q;
  assign out_o.light_mode    = light_mode_q;
  assign out_o.good_frames   = good_q;
  assign out_o.bad_frames    = bad_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.done |-> (!valid_q || out_o.ready))
    else $error("frame result overwrites an untaken result");

  a_one_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.done |=> ((good_q + bad_q) == ($past(good_q + bad_q) + 32'd1)))
    else $error("frame not counted exactly once");

  a_known_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (!known_q || ok_q))
    else $error("command applied on bad crc");

endmodule
